// ===== hdl/ssc_pkg.sv =====
package ssc_pkg;

    localparam int FREQ_W   = 49;
    localparam int LOG_FRAC = 24;
    localparam int LOG_W    = 29;
    localparam int ATAN_N   = 24;

    localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [2:0] REG_START_FREQ  = 3'd1;
    localparam logic [2:0] REG_END_FREQ    = 3'd2;
    localparam logic [2:0] REG_DURATION    = 3'd3;
    localparam logic [2:0] REG_LOG_CURVE   = 3'd4;
    localparam logic [2:0] REG_ONE_SHOT    = 3'd5;
    localparam logic [2:0] REG_TAPER       = 3'd6;

    localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
    localparam logic [32:0] CORDIC_GAIN = 33'd652032874;
    localparam logic [32:0] ONE_Q30     = 33'd1073741824;

    typedef logic [ATAN_N-1:0][31:0] atan_tab_t;
    typedef logic [LOG_FRAC:1][31:0] exp_tab_t;

    localparam atan_tab_t ATAN_TAB = {
        32'd128, 32'd256, 32'd512, 32'd1024, 32'd2048, 32'd4096,
        32'd8192, 32'd16384, 32'd32768, 32'd65536, 32'd131072, 32'd262144,
        32'd524288, 32'd1048576, 32'd2097149, 32'd4194283, 32'd8388437,
        32'd16775851, 32'd33543516, 32'd67021687, 32'd133525159,
        32'd263043837, 32'd497837829, 32'd843314857
    };

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) begin
            bitv = bitv >> 2;
        end
        while (bitv != 64'd0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Roots of two in Q1.31: entry k is 2 to the power of 2^-k.
    function automatic exp_tab_t calc_exp_tab();
        exp_tab_t    t;
        logic [63:0] c;
        c = 64'd1 << 32;
        for (int k = 1; k <= LOG_FRAC; k++) begin
            c    = isqrt64(c << 31);
            t[k] = c[31:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = calc_exp_tab();

endpackage

// ===== hdl/swept_sine_chirp_generator.sv =====
// Swept sine generator: each input beat is one sample tick and yields one output beat
// carrying the next sample of a linear or exponential sweep between the start and end
// frequencies, optionally shaped by raised-cosine fades at both ends. An exponential sweep
// adds a logarithm of both end frequencies and one extra multiply step for each set
// fraction bit of the interpolated exponent. Reducing the position modulo the duration
// takes a further division. The taper adds finding the fade length, and inside a fade a
// division and a second CORDIC pass. A finished one-shot sweep emits a zero sample with
// sweep_done set. NUM_W is 64 for phase widths up to 47 bits. The time per sample is set
// by one shared restoring divider that yields one quotient bit a cycle, one shared
// multiplier whose product is registered, and one CORDIC stage iterated once a cycle.
// The input is not ready while a sample is in progress; a finished sample waits in the
// output register while the next beat is taken.
module swept_sine_chirp_generator #(
    parameter int PHASE_BITS   = 32,
    parameter int OUTPUT_BITS  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [((OUTPUT_BITS+7)/8)*8-1:0] m_tdata,  // [OUTPUT_BITS-1:0] sample_out
    output logic        m_tuser,   // [0] sweep_done
    output logic        m_tlast
);
    import ssc_pkg::*;

    localparam int SH_L  = (PHASE_BITS > 32) ? PHASE_BITS - 32 : 0;
    localparam int SH_R  = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;
    localparam int NUM_W = (FREQ_W + SH_L > 64) ? FREQ_W + SH_L : 64;
    localparam int DCW   = $clog2(NUM_W + 1);
    localparam int CCW   = $clog2(CORDIC_STEPS);
    localparam int TDW   = ((OUTPUT_BITS + 7) / 8) * 8;
    localparam int MAGW  = OUTPUT_BITS - 1;
    localparam logic [MAGW-1:0] OUT_MAX = {MAGW{1'b1}};
    localparam logic [31:0] RECIP_25 = 32'd171798692;
    localparam logic [31:0] RECIP_5  = 32'd3435973837;

    localparam logic [4:0] S_IDLE = 5'd0,  S_POS  = 5'd1,  S_MODR = 5'd2,  S_UST  = 5'd3,
                           S_DIV  = 5'd4,  S_FREQ = 5'd5,  S_LIN  = 5'd6,  S_LOGI = 5'd7,
                           S_LSQ  = 5'd8,  S_LSQ2 = 5'd9,  S_EMUL = 5'd10, S_E    = 5'd11,
                           S_EXP  = 5'd12, S_EXP2 = 5'd13, S_INC  = 5'd14, S_PH   = 5'd15,
                           S_W    = 5'd16, S_QA   = 5'd17, S_COR  = 5'd18, S_SIN  = 5'd19,
                           S_FR   = 5'd20, S_FD   = 5'd21, S_A    = 5'd22, S_QA2  = 5'd23,
                           S_ENV  = 5'd24, S_ENV2 = 5'd25, S_M1   = 5'd26, S_M2   = 5'd27,
                           S_M3   = 5'd28, S_M4   = 5'd29, S_OUT  = 5'd30, S_FQ   = 5'd31;

    logic [4:0]  state_reg, state_next, ret_reg, ret_next;
    logic [17:0] rate_reg, rate_next;
    logic [16:0] start_reg, start_next, end_reg, end_next;
    logic [31:0] dur_reg, dur_next;
    logic        log_reg, log_next, one_shot_reg, one_shot_next, taper_reg, taper_next;
    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic        m_valid_reg, m_valid_next;

    logic        last_reg, last_next;
    logic [31:0] p_reg, p_next, u_reg, u_next;
    logic [FREQ_W-1:0] freq_reg, freq_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] mul_a, mul_b;
    logic [NUM_W-1:0] div_num_reg, div_num_next;
    logic [31:0] div_rem_reg, div_rem_next, div_den_reg, div_den_next;
    logic [DCW-1:0] div_cnt_reg, div_cnt_next;
    logic [31:0] m_reg, m_next;
    logic [LOG_FRAC-1:0] frac_reg, frac_next;
    logic [4:0]  lint_reg, lint_next, lcnt_reg, lcnt_next, kcnt_reg, kcnt_next;
    logic        lsel_reg, lsel_next;
    logic [LOG_W-1:0] ls_reg, ls_next, le_reg, le_next, e_reg, e_next;
    logic signed [32:0] cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [CCW-1:0] ccnt_reg, ccnt_next;
    logic [30:0] mag_reg, mag_next, env_reg, env_next;
    logic        neg_reg, neg_next;
    logic [31:0] fr_reg, fr_next;
    logic [OUTPUT_BITS-1:0] res_sample_reg, res_sample_next, m_sample_reg, m_sample_next;
    logic        res_done_reg, res_done_next, m_done_reg, m_done_next;
    logic        m_last_reg, m_last_next;

    logic [17:0] rate_eff;
    logic [19:0] rate3;
    logic [31:0] dur_eff;
    logic [16:0] fdiff;
    logic [LOG_W-1:0] ediff;
    logic [32:0] trial;
    logic [79:0] w_full;
    logic [31:0] w;
    logic [30:0] cos_c, sin_c;
    logic [16:0] lx;
    logic [4:0]  ln;
    logic [32:0] sq;
    logic [31:0] fd, fade, kk;
    logic [63:0] rnd;
    logic [MAGW-1:0] mag_out;
    logic signed [32:0] cdx, cdy;
    logic [31:0] atan_v;

    assign rate_eff = (rate_reg == 18'd0) ? 18'd1 : rate_reg;
    assign rate3    = 20'(rate_eff) + (20'(rate_eff) << 1);
    assign dur_eff  = (dur_reg == 32'd0) ? 32'd1 : dur_reg;
    assign fdiff    = (end_reg >= start_reg) ? end_reg - start_reg : start_reg - end_reg;
    assign ediff    = (le_reg >= ls_reg) ? le_reg - ls_reg : ls_reg - le_reg;
    assign trial    = {div_rem_reg, div_num_reg[NUM_W-1]};
    assign w_full   = (80'(phase_reg) << SH_R) >> SH_L;
    assign w        = w_full[31:0];
    assign cos_c    = cx_reg[32] ? 31'd0 : (cx_reg > $signed(ONE_Q30)) ? 31'(ONE_Q30)
                                                                         : cx_reg[30:0];
    assign sin_c    = cy_reg[32] ? 31'd0 : (cy_reg > $signed(ONE_Q30)) ? 31'(ONE_Q30)
                                                                         : cy_reg[30:0];
    assign lx       = lsel_reg ? ((end_reg == 17'd0) ? 17'd1 : end_reg)
                               : ((start_reg == 17'd0) ? 17'd1 : start_reg);
    assign sq       = prod_reg[63:31];
    assign cdx      = cy_reg >>> ccnt_reg;
    assign cdy      = cx_reg >>> ccnt_reg;
    assign atan_v   = ATAN_TAB[5'(ccnt_reg)];
    assign fd       = {2'b00, prod_reg[63:34]};
    assign fade     = (fr_reg < fd) ? fr_reg : fd;
    assign kk       = (p_reg < fade) ? p_reg : dur_eff - p_reg;
    assign rnd      = (prod_reg + (64'd1 << 29)) >> 30;
    assign mag_out  = (rnd > 64'(OUT_MAX)) ? OUT_MAX : rnd[MAGW-1:0];

    always_comb begin
        ln = 5'd0;
        for (int i = 0; i < 17; i++) begin
            if (lx[i]) begin
                ln = 5'(i);
            end
        end
    end

    always_comb begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (state_reg)
            S_FREQ: begin
                mul_a = 32'(fdiff);
                mul_b = div_num_reg[31:0];
            end
            S_LSQ: begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_EMUL: begin
                mul_a = 32'(ediff);
                mul_b = u_reg;
            end
            S_EXP: begin
                mul_a = m_reg;
                mul_b = EXP_TAB[kcnt_reg];
            end
            S_W: begin
                mul_a = {2'b00, w[29:0]};
                mul_b = HALF_PI_Q30;
            end
            S_FR: begin
                mul_a = 32'(rate3[19:3]);
                mul_b = RECIP_25;
            end
            S_FQ: begin
                mul_a = {2'b00, dur_eff[31:2]};
                mul_b = RECIP_5;
            end
            S_A: begin
                mul_a = (div_num_reg >= NUM_W'(32'h3FFFFFFF)) ? 32'h3FFFFFFF
                                                              : div_num_reg[31:0];
                mul_b = HALF_PI_Q30;
            end
            S_ENV: begin
                mul_a = 32'(sin_c);
                mul_b = 32'(sin_c);
            end
            S_M1: begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(env_reg);
            end
            S_M3: begin
                mul_a = 32'(mag_reg);
                mul_b = 32'(OUT_MAX);
            end
            default: begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        rate_next       = rate_reg;
        start_next      = start_reg;
        end_next        = end_reg;
        dur_next        = dur_reg;
        log_next        = log_reg;
        one_shot_next   = one_shot_reg;
        taper_next      = taper_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        m_valid_next    = m_valid_reg;
        last_next       = last_reg;
        p_next          = p_reg;
        u_next          = u_reg;
        freq_next       = freq_reg;
        prod_next       = {32'd0, mul_a} * {32'd0, mul_b};
        div_num_next    = div_num_reg;
        div_rem_next    = div_rem_reg;
        div_den_next    = div_den_reg;
        div_cnt_next    = div_cnt_reg;
        m_next          = m_reg;
        frac_next       = frac_reg;
        lint_next       = lint_reg;
        lcnt_next       = lcnt_reg;
        kcnt_next       = kcnt_reg;
        lsel_next       = lsel_reg;
        ls_next         = ls_reg;
        le_next         = le_reg;
        e_next          = e_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        ccnt_next       = ccnt_reg;
        mag_next        = mag_reg;
        env_next        = env_reg;
        neg_next        = neg_reg;
        fr_next         = fr_reg;
        res_sample_next = res_sample_reg;
        res_done_next   = res_done_reg;
        m_sample_next   = m_sample_reg;
        m_done_next     = m_done_reg;
        m_last_next     = m_last_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_SAMPLE_RATE: rate_next     = cfg_data[17:0];
                REG_START_FREQ:  start_next    = cfg_data[16:0];
                REG_END_FREQ:    end_next      = cfg_data[16:0];
                REG_DURATION:    dur_next      = cfg_data;
                REG_LOG_CURVE:   log_next      = cfg_data[0];
                REG_ONE_SHOT:    one_shot_next = cfg_data[0];
                REG_TAPER:       taper_next    = cfg_data[0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    last_next = s_tlast;
                    if (s_tdata[0]) begin
                        phase_next = '0;
                        pos_next   = 32'd0;
                    end
                    state_next = S_POS;
                end
            end
            S_POS: begin
                if (one_shot_reg) begin
                    p_next = pos_reg;
                    if (pos_reg != 32'hFFFFFFFF) begin
                        pos_next = pos_reg + 32'd1;
                    end
                    if (pos_reg >= dur_eff) begin
                        res_sample_next = '0;
                        res_done_next   = 1'b1;
                        state_next      = S_OUT;
                    end else begin
                        state_next = S_UST;
                    end
                end else if (pos_reg >= dur_eff) begin
                    div_num_next = NUM_W'(pos_reg);
                    div_den_next = dur_eff;
                    div_rem_next = 32'd0;
                    div_cnt_next = DCW'(NUM_W);
                    ret_next     = S_MODR;
                    state_next   = S_DIV;
                end else begin
                    p_next     = pos_reg;
                    pos_next   = (33'(pos_reg) + 33'd1 == 33'(dur_eff)) ? 32'd0
                                                                        : pos_reg + 32'd1;
                    state_next = S_UST;
                end
            end
            S_MODR: begin
                p_next     = div_rem_reg;
                pos_next   = (33'(div_rem_reg) + 33'd1 == 33'(dur_eff)) ? 32'd0
                                                                        : div_rem_reg + 32'd1;
                state_next = S_UST;
            end
            S_UST: begin
                div_num_next = NUM_W'({p_reg, 32'd0});
                div_den_next = dur_eff;
                div_rem_next = 32'd0;
                div_cnt_next = DCW'(NUM_W);
                ret_next     = S_FREQ;
                state_next   = S_DIV;
            end
            S_DIV: begin
                if (trial >= {1'b0, div_den_reg}) begin
                    div_rem_next = 32'(trial - {1'b0, div_den_reg});
                    div_num_next = {div_num_reg[NUM_W-2:0], 1'b1};
                end else begin
                    div_rem_next = trial[31:0];
                    div_num_next = {div_num_reg[NUM_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1)) begin
                    state_next = ret_reg;
                end
            end
            S_FREQ: begin
                u_next = div_num_reg[31:0];
                if (log_reg) begin
                    lsel_next  = 1'b0;
                    state_next = S_LOGI;
                end else begin
                    state_next = S_LIN;
                end
            end
            S_LIN: begin
                if (end_reg >= start_reg) begin
                    freq_next = {start_reg, 32'd0} + prod_reg[FREQ_W-1:0];
                end else begin
                    freq_next = {start_reg, 32'd0} - prod_reg[FREQ_W-1:0];
                end
                state_next = S_INC;
            end
            S_LOGI: begin
                m_next     = 32'({15'd0, lx}) << (5'd31 - ln);
                frac_next  = '0;
                lint_next  = ln;
                lcnt_next  = 5'd0;
                state_next = S_LSQ;
            end
            S_LSQ: begin
                state_next = S_LSQ2;
            end
            S_LSQ2: begin
                frac_next = {frac_reg[LOG_FRAC-2:0], sq[32]};
                m_next    = sq[32] ? sq[32:1] : sq[31:0];
                lcnt_next = lcnt_reg + 5'd1;
                if (lcnt_reg == 5'(LOG_FRAC - 1)) begin
                    if (lsel_reg) begin
                        le_next    = {lint_reg, frac_reg[LOG_FRAC-2:0], sq[32]};
                        state_next = S_EMUL;
                    end else begin
                        ls_next    = {lint_reg, frac_reg[LOG_FRAC-2:0], sq[32]};
                        lsel_next  = 1'b1;
                        state_next = S_LOGI;
                    end
                end else begin
                    state_next = S_LSQ;
                end
            end
            S_EMUL: begin
                state_next = S_E;
            end
            S_E: begin
                if (le_reg >= ls_reg) begin
                    e_next = ls_reg + prod_reg[LOG_W+31:32];
                end else begin
                    e_next = ls_reg - prod_reg[LOG_W+31:32];
                end
                m_next     = 32'h80000000;
                kcnt_next  = 5'd1;
                state_next = S_EXP;
            end
            S_EXP: begin
                if (kcnt_reg > 5'(LOG_FRAC)) begin
                    freq_next  = FREQ_W'({m_reg, 1'b0}) <<
                                 ((e_reg[LOG_W-1:LOG_FRAC] > 5'd16) ? 5'd16
                                                                     : e_reg[LOG_W-1:LOG_FRAC]);
                    state_next = S_INC;
                end else if (e_reg[5'(5'(LOG_FRAC) - kcnt_reg)]) begin
                    state_next = S_EXP2;
                end else begin
                    kcnt_next = kcnt_reg + 5'd1;
                end
            end
            S_EXP2: begin
                m_next     = prod_reg[62:31];
                kcnt_next  = kcnt_reg + 5'd1;
                state_next = S_EXP;
            end
            S_INC: begin
                div_num_next = (NUM_W'(freq_reg) << SH_L) >> SH_R;
                div_den_next = 32'(rate_eff);
                div_rem_next = 32'd0;
                div_cnt_next = DCW'(NUM_W);
                ret_next     = S_PH;
                state_next   = S_DIV;
            end
            S_PH: begin
                phase_next = phase_reg + div_num_reg[PHASE_BITS-1:0];
                state_next = S_W;
            end
            S_W: begin
                state_next = S_QA;
            end
            S_QA: begin
                cx_next    = $signed(CORDIC_GAIN);
                cy_next    = '0;
                cz_next    = $signed({2'b00, prod_reg[60:30]});
                ccnt_next  = '0;
                ret_next   = S_SIN;
                state_next = S_COR;
            end
            S_COR: begin
                if (!cz_reg[32]) begin
                    cx_next = cx_reg - cdx;
                    cy_next = cy_reg + cdy;
                    cz_next = cz_reg - $signed({1'b0, atan_v});
                end else begin
                    cx_next = cx_reg + cdx;
                    cy_next = cy_reg - cdy;
                    cz_next = cz_reg + $signed({1'b0, atan_v});
                end
                ccnt_next = ccnt_reg + CCW'(1);
                if (ccnt_reg == CCW'(CORDIC_STEPS - 1)) begin
                    state_next = ret_reg;
                end
            end
            S_SIN: begin
                mag_next = w[30] ? cos_c : sin_c;
                neg_next = w[31];
                if (taper_reg) begin
                    state_next = S_FR;
                end else begin
                    env_next   = 31'(ONE_Q30);
                    state_next = S_M1;
                end
            end
            S_FR: begin
                state_next = S_FQ;
            end
            S_FQ: begin
                fr_next    = prod_reg[63:32];
                state_next = S_FD;
            end
            S_FD: begin
                if (fade != 32'd0 &&
                    (p_reg < fade || 33'(p_reg) + 33'(fade) > 33'(dur_eff))) begin
                    div_num_next = NUM_W'({kk, 30'd0});
                    div_den_next = fade;
                    div_rem_next = 32'd0;
                    div_cnt_next = DCW'(NUM_W);
                    ret_next     = S_A;
                    state_next   = S_DIV;
                end else begin
                    env_next   = 31'(ONE_Q30);
                    state_next = S_M1;
                end
            end
            S_A: begin
                state_next = S_QA2;
            end
            S_QA2: begin
                cx_next    = $signed(CORDIC_GAIN);
                cy_next    = '0;
                cz_next    = $signed({2'b00, prod_reg[60:30]});
                ccnt_next  = '0;
                ret_next   = S_ENV;
                state_next = S_COR;
            end
            S_ENV: begin
                state_next = S_ENV2;
            end
            S_ENV2: begin
                env_next   = prod_reg[60:30];
                state_next = S_M1;
            end
            S_M1: begin
                state_next = S_M2;
            end
            S_M2: begin
                mag_next   = prod_reg[60:30];
                state_next = S_M3;
            end
            S_M3: begin
                state_next = S_M4;
            end
            S_M4: begin
                res_sample_next = neg_reg ? OUTPUT_BITS'(-$signed({1'b0, mag_out}))
                                          : OUTPUT_BITS'({1'b0, mag_out});
                res_done_next   = 1'b0;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_done_next   = res_done_reg;
                    m_last_next   = last_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ret_reg      <= S_IDLE;
            rate_reg     <= 18'd48000;
            start_reg    <= 17'd20;
            end_reg      <= 17'd20000;
            dur_reg      <= 32'd480000;
            log_reg      <= 1'b0;
            one_shot_reg <= 1'b0;
            taper_reg    <= 1'b0;
            phase_reg    <= '0;
            pos_reg      <= 32'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ret_reg      <= ret_next;
            rate_reg     <= rate_next;
            start_reg    <= start_next;
            end_reg      <= end_next;
            dur_reg      <= dur_next;
            log_reg      <= log_next;
            one_shot_reg <= one_shot_next;
            taper_reg    <= taper_next;
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_reg       <= last_next;
        p_reg          <= p_next;
        u_reg          <= u_next;
        freq_reg       <= freq_next;
        prod_reg       <= prod_next;
        div_num_reg    <= div_num_next;
        div_rem_reg    <= div_rem_next;
        div_den_reg    <= div_den_next;
        div_cnt_reg    <= div_cnt_next;
        m_reg          <= m_next;
        frac_reg       <= frac_next;
        lint_reg       <= lint_next;
        lcnt_reg       <= lcnt_next;
        kcnt_reg       <= kcnt_next;
        lsel_reg       <= lsel_next;
        ls_reg         <= ls_next;
        le_reg         <= le_next;
        e_reg          <= e_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        ccnt_reg       <= ccnt_next;
        mag_reg        <= mag_next;
        env_reg        <= env_next;
        neg_reg        <= neg_next;
        fr_reg         <= fr_next;
        res_sample_reg <= res_sample_next;
        res_done_reg   <= res_done_next;
        m_sample_reg   <= m_sample_next;
        m_done_reg     <= m_done_next;
        m_last_reg     <= m_last_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDW'(m_sample_reg);
    assign m_tuser  = m_done_reg;
    assign m_tlast  = m_last_reg;

endmodule
